### sv/mtel_pkg.sv
// Shared constants, register codes and lane interface types for the lattice step block.
`default_nettype none

package mtel_pkg;

    // Lattice geometry
    localparam int CELLS    = 64;
    localparam int CHANNELS = 4;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Field widths
    localparam int CHAN_W    = 4;
    localparam int PROB_W    = 17;
    localparam int DRAW_W    = 16;
    localparam int SITE_W    = 6;
    localparam int COUNT_W   = 6;
    localparam int CFG_IDX_W = 3;

    // Lane split of one row
    localparam int LANE_W = 8;
    localparam int LANES  = (CELLS + LANE_W - 1) / LANE_W;
    localparam int PAD_W  = LANES * LANE_W;
    localparam int LCNT_W = $clog2(LANE_W + 1);
    localparam int SUM_W  = $clog2(PAD_W + 1);

    // Register reset values
    localparam logic [PROB_W-1:0] ENTRY_RESET  = 17'd6554;
    localparam logic [PROB_W-1:0] EXIT_RESET   = 17'd6554;
    localparam logic [PROB_W-1:0] ATTACH_RESET = 17'd0;
    localparam logic [PROB_W-1:0] DETACH_RESET = 17'd0;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENTRY   = 3'd0,
        CFG_EXIT    = 3'd1,
        CFG_ATTACH  = 3'd2,
        CFG_DETACH  = 3'd3,
        CFG_LATERAL = 3'd4
    } cfg_idx_t;

    // What one lane sees of the row
    typedef struct packed {
        logic [LANE_W-1:0] row;
        logic [LANE_W-1:0] rsh;
        logic [LANE_W-1:0] span;
        logic [LANE_W-1:0] hop;
        logic [LANE_W-1:0] up_first;
        logic [LANE_W-1:0] a_row;
        logic [LANE_W-1:0] b_row;
        logic              lat_en;
    } lane_in_t;

    // What one lane found
    typedef struct packed {
        logic [LANE_W-1:0] hops;
        logic [LANE_W-1:0] go_up;
        logic [LANE_W-1:0] go_dn;
        logic [LCNT_W-1:0] hop_cnt;
        logic [LCNT_W-1:0] lat_cnt;
    } lane_out_t;

endpackage

`default_nettype wire

### sv/mtel_ram.sv
// Generic single-write, dual-read RAM with registered read data.
`default_nettype none

module mtel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                                          clk,
    input  wire logic                                          we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  wire logic [WIDTH-1:0]                              wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr0,
    output logic      [WIDTH-1:0]                              rdata0,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr1,
    output logic      [WIDTH-1:0]                              rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read ports, registered
    always_ff @(posedge clk)
    begin
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

`default_nettype wire

### sv/mtel_lane.sv
// One lane: forward hop and lateral move decisions for a slice of cells, with slice counts.
`default_nettype none

module mtel_lane (
    input  wire mtel_pkg::lane_in_t  lin,
    output mtel_pkg::lane_out_t      lout
);

    localparam int LW = mtel_pkg::LANE_W;
    localparam int CW = mtel_pkg::LCNT_W;

    logic [LW-1:0] hops;
    logic [LW-1:0] blocked;
    logic [LW-1:0] up_pref;
    logic [LW-1:0] dn_pref;
    logic [LW-1:0] go_up;
    logic [LW-1:0] go_dn;
    logic [LW-1:0] moved;
    logic [CW-1:0] hop_cnt;
    logic [CW-1:0] lat_cnt;

    // Hop into an empty next cell; a particle with an occupied next cell is blocked
    assign hops    = lin.row & lin.span & ~lin.rsh & lin.hop;
    assign blocked = lin.row & lin.span & lin.rsh;

    // Blocked particles try their first side, then the other
    assign up_pref = blocked & lin.up_first;
    assign dn_pref = blocked & ~lin.up_first;
    assign go_up   = lin.lat_en ? ((up_pref & ~lin.a_row) | (dn_pref & lin.b_row & ~lin.a_row))
                                : '0;
    assign go_dn   = lin.lat_en ? ((dn_pref & ~lin.b_row) | (up_pref & lin.a_row & ~lin.b_row))
                                : '0;
    assign moved   = go_up | go_dn;

    // Slice population counts
    always_comb
    begin
        hop_cnt = '0;
        lat_cnt = '0;
        for (int i = 0; i < LW; i++)
        begin
            hop_cnt = hop_cnt + CW'(hops[i]);
            lat_cnt = lat_cnt + CW'(moved[i]);
        end
    end

    assign lout.hops    = hops;
    assign lout.go_up   = go_up;
    assign lout.go_dn   = go_dn;
    assign lout.hop_cnt = hop_cnt;
    assign lout.lat_cnt = lat_cnt;

endmodule

`default_nettype wire

### sv/mtel_merge.sv
// Merge stage: adds the registered per-lane hop and lateral counts.
`default_nettype none

module mtel_merge (
    input  wire logic [mtel_pkg::LANES-1:0][mtel_pkg::LCNT_W-1:0] lane_hop_cnt,
    input  wire logic [mtel_pkg::LANES-1:0][mtel_pkg::LCNT_W-1:0] lane_lat_cnt,
    output logic      [mtel_pkg::COUNT_W-1:0]                     hop_count,
    output logic      [mtel_pkg::COUNT_W-1:0]                     lateral_count
);

    localparam int SW = mtel_pkg::SUM_W;
    localparam int OW = mtel_pkg::COUNT_W;

    logic [SW-1:0] hop_sum;
    logic [SW-1:0] lat_sum;

    // Sum over lanes
    always_comb
    begin
        hop_sum = '0;
        lat_sum = '0;
        for (int l = 0; l < mtel_pkg::LANES; l++)
        begin
            hop_sum = hop_sum + SW'(lane_hop_cnt[l]);
            lat_sum = lat_sum + SW'(lane_lat_cnt[l]);
        end
    end

    // Counts are reported modulo the field width
    assign hop_count     = hop_sum[OW-1:0];
    assign lateral_count = lat_sum[OW-1:0];

endmodule

`default_nettype wire

### sv/multichannel_exclusion_lattice_step.sv
// Top level: ring of occupancy channels, one channel updated per input beat.
//
// Each input beat updates one channel: entry at cell 0, exit at the last cell, parallel
// forward hops, optional lateral moves into the channels above and below, then attach and
// detach at the given sites; one result beat follows. The channel rows live in a small RAM
// with one write port and two registered read ports, so a beat passes from accept to the next
// accept through read, second read, compute and write-back of the row, and result load;
// when lateral moves are enabled the rows above and below are written back after the row,
// one per cycle through the single write port. The hop and lateral decisions run in
// 8-cell lanes whose counts are summed by a merge stage ahead of the output register. A
// result waiting on a stalled output does not keep the next beat from being accepted. After
// reset every channel reads as empty through per-channel valid bits; no clearing pass is
// needed. A channel index at or above the channel count changes no state and returns a row
// of zero with all flags and counts zero.
`default_nettype none

module multichannel_exclusion_lattice_step (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    // Configuration write port
    input  wire logic                               cfg_write,
    input  wire logic [mtel_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mtel_pkg::PROB_W-1:0]        cfg_data,

    // Input channel
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [mtel_pkg::CHAN_W-1:0]        channel,
    input  wire logic [mtel_pkg::DRAW_W-1:0]        entry_draw,
    input  wire logic [mtel_pkg::DRAW_W-1:0]        exit_draw,
    input  wire logic [mtel_pkg::CELLS-1:0]         hop_mask,
    input  wire logic [mtel_pkg::CELLS-1:0]         up_first_mask,
    input  wire logic [mtel_pkg::SITE_W-1:0]        attach_site,
    input  wire logic [mtel_pkg::DRAW_W-1:0]        attach_draw,
    input  wire logic [mtel_pkg::SITE_W-1:0]        detach_site,
    input  wire logic [mtel_pkg::DRAW_W-1:0]        detach_draw,

    // Output channel
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic      [mtel_pkg::CHAN_W-1:0]        updated_channel,
    output logic      [mtel_pkg::CELLS-1:0]         row_bits,
    output logic                                    entered,
    output logic                                    exited,
    output logic      [mtel_pkg::COUNT_W-1:0]       hop_count,
    output logic      [mtel_pkg::COUNT_W-1:0]       lateral_count,
    output logic                                    attached,
    output logic                                    detached
);

    localparam int CELLS    = mtel_pkg::CELLS;
    localparam int CHANNELS = mtel_pkg::CHANNELS;
    localparam int CH_W     = mtel_pkg::CH_W;
    localparam int LW       = mtel_pkg::LANE_W;
    localparam int LANES    = mtel_pkg::LANES;
    localparam int PAD_W    = mtel_pkg::PAD_W;
    localparam int LCNT_W   = mtel_pkg::LCNT_W;
    localparam int PROB_W   = mtel_pkg::PROB_W;

    localparam logic [CELLS-1:0] LAST_BIT  = {1'b1, {(CELLS-1){1'b0}}};
    localparam logic [CELLS-1:0] SPAN_FULL = {1'b0, {(CELLS-1){1'b1}}};
    localparam logic [CELLS-1:0] SPAN_EXIT = {2'b00, {(CELLS-2){1'b1}}};
    localparam logic [CELLS-1:0] ONE_BIT   = {{(CELLS-1){1'b0}}, 1'b1};
    localparam logic [CH_W-1:0]  CH_LAST   = CH_W'(CHANNELS - 1);

    // Sequencer states
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD2  = 6'b000010,
        S_CALC = 6'b000100,
        S_WRA  = 6'b001000,
        S_WRB  = 6'b010000,
        S_DONE = 6'b100000
    } st_t;

    st_t st_reg;
    st_t st_next;

    // Configuration registers
    logic [PROB_W-1:0] entry_prob_reg;
    logic [PROB_W-1:0] exit_prob_reg;
    logic [PROB_W-1:0] attach_prob_reg;
    logic [PROB_W-1:0] detach_prob_reg;
    logic              lat_en_reg;

    // Channel valid bits and read-side samples
    logic [CHANNELS-1:0] vld_reg;
    logic                rd_vld0_reg;
    logic                rd_vld1_reg;

    // Captured input beat
    logic [mtel_pkg::CHAN_W-1:0] ch_reg;
    logic [CH_W-1:0]             k_reg;
    logic [CH_W-1:0]             above_reg;
    logic [CH_W-1:0]             below_reg;
    logic                        oor_reg;
    logic [mtel_pkg::DRAW_W-1:0] e_draw_reg;
    logic [mtel_pkg::DRAW_W-1:0] x_draw_reg;
    logic [CELLS-1:0]            hop_reg;
    logic [CELLS-1:0]            up_reg;
    logic [mtel_pkg::SITE_W-1:0] a_site_reg;
    logic [mtel_pkg::DRAW_W-1:0] a_draw_reg;
    logic [mtel_pkg::SITE_W-1:0] d_site_reg;
    logic [mtel_pkg::DRAW_W-1:0] d_draw_reg;

    // Step results
    logic [CELLS-1:0] a_row_reg;
    logic [CELLS-1:0] b_row_reg;
    logic [CELLS-1:0] res_row_reg;
    logic [CELLS-1:0] go_up_reg;
    logic [CELLS-1:0] go_dn_reg;
    logic             ent_reg;
    logic             ext_reg;
    logic             att_reg;
    logic             det_reg;
    logic [LANES-1:0][LCNT_W-1:0] lane_hop_cnt_reg;
    logic [LANES-1:0][LCNT_W-1:0] lane_lat_cnt_reg;

    // Output register
    logic                         out_valid_reg;
    logic [mtel_pkg::CHAN_W-1:0]  updated_channel_reg;
    logic [CELLS-1:0]             row_bits_reg;
    logic                         entered_reg;
    logic                         exited_reg;
    logic [mtel_pkg::COUNT_W-1:0] hop_count_reg;
    logic [mtel_pkg::COUNT_W-1:0] lateral_count_reg;
    logic                         attached_reg;
    logic                         detached_reg;

    // Combinational
    logic             accept;
    logic             in_ok;
    logic [CH_W-1:0]  k_in;
    logic [CH_W-1:0]  above_in;
    logic [CH_W-1:0]  below_in;
    logic [CH_W-1:0]  raddr0;
    logic [CH_W-1:0]  raddr1;
    logic             vld_lk0;
    logic             vld_lk1;
    logic [CELLS-1:0] rdata0;
    logic [CELLS-1:0] rdata1;
    logic             ram_we;
    logic [CH_W-1:0]  ram_waddr;
    logic [CELLS-1:0] ram_wdata;
    logic             out_load;
    logic             out_take;

    logic [CELLS-1:0] row0;
    logic [CELLS-1:0] row1;
    logic [CELLS-1:0] row2;
    logic [CELLS-1:0] row3;
    logic [CELLS-1:0] row4;
    logic [CELLS-1:0] row5;
    logic [CELLS-1:0] row6;
    logic [CELLS-1:0] b_row;
    logic [CELLS-1:0] span;
    logic [CELLS-1:0] rsh;
    logic [CELLS-1:0] hops;
    logic [CELLS-1:0] go_up;
    logic [CELLS-1:0] go_dn;
    logic [CELLS-1:0] a_bit;
    logic [CELLS-1:0] d_bit;
    logic             e_fire;
    logic             x_fire;
    logic             ent;
    logic             ext;
    logic             att;
    logic             det;
    logic             a_in;
    logic             d_in;

    logic [PAD_W-1:0] row_pad;
    logic [PAD_W-1:0] rsh_pad;
    logic [PAD_W-1:0] span_pad;
    logic [PAD_W-1:0] hop_pad;
    logic [PAD_W-1:0] up_pad;
    logic [PAD_W-1:0] a_pad;
    logic [PAD_W-1:0] b_pad;
    wire  [PAD_W-1:0] hops_pad;
    wire  [PAD_W-1:0] go_up_pad;
    wire  [PAD_W-1:0] go_dn_pad;
    wire  [LANES-1:0][LCNT_W-1:0] lane_hop_cnt;
    wire  [LANES-1:0][LCNT_W-1:0] lane_lat_cnt;
    logic [mtel_pkg::COUNT_W-1:0] hop_sum;
    logic [mtel_pkg::COUNT_W-1:0] lat_sum;

    // Handshakes
    assign in_stall = (st_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;
    assign out_load = (st_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // Channel ring neighbors of the incoming beat
    assign in_ok    = (int'(channel) < CHANNELS);
    assign k_in     = channel[CH_W-1:0];
    assign above_in = (k_in == '0) ? CH_LAST : (k_in - CH_W'(1));
    assign below_in = (k_in == CH_LAST) ? '0 : (k_in + CH_W'(1));

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_prob_reg  <= mtel_pkg::ENTRY_RESET;
            exit_prob_reg   <= mtel_pkg::EXIT_RESET;
            attach_prob_reg <= mtel_pkg::ATTACH_RESET;
            detach_prob_reg <= mtel_pkg::DETACH_RESET;
            lat_en_reg      <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mtel_pkg::CFG_ENTRY:   entry_prob_reg  <= cfg_data;
                mtel_pkg::CFG_EXIT:    exit_prob_reg   <= cfg_data;
                mtel_pkg::CFG_ATTACH:  attach_prob_reg <= cfg_data;
                mtel_pkg::CFG_DETACH:  detach_prob_reg <= cfg_data;
                mtel_pkg::CFG_LATERAL: lat_en_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE: if (accept) st_next = in_ok ? S_RD2 : S_DONE;
            S_RD2:  st_next = S_CALC;
            S_CALC: st_next = lat_en_reg ? S_WRA : S_DONE;
            S_WRA:  st_next = S_WRB;
            S_WRB:  st_next = S_DONE;
            S_DONE: if (out_load) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    // RAM read addresses: current row and the row above at accept, then the row below
    assign raddr0  = (st_reg == S_IDLE) ? k_in : k_reg;
    assign raddr1  = (st_reg == S_IDLE) ? above_in : below_reg;
    assign vld_lk0 = (int'(raddr0) < CHANNELS) ? vld_reg[raddr0] : 1'b0;
    assign vld_lk1 = (int'(raddr1) < CHANNELS) ? vld_reg[raddr1] : 1'b0;

    // RAM write-back: own row, then above and below when lateral moves are on
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = k_reg;
        ram_wdata = row6;
        unique case (st_reg)
            S_CALC:
            begin
                ram_we    = 1'b1;
                ram_waddr = k_reg;
                ram_wdata = row6;
            end
            S_WRA:
            begin
                ram_we    = 1'b1;
                ram_waddr = above_reg;
                ram_wdata = a_row_reg | go_up_reg;
            end
            S_WRB:
            begin
                ram_we    = 1'b1;
                ram_waddr = below_reg;
                ram_wdata = ((above_reg == below_reg) ? (a_row_reg | go_up_reg) : b_row_reg)
                            | go_dn_reg;
            end
            default: ;
        endcase
    end

    mtel_ram #(
        .WIDTH (CELLS),
        .DEPTH (CHANNELS)
    ) u_ram (
        .clk    (clk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .raddr0 (raddr0),
        .rdata0 (rdata0),
        .raddr1 (raddr1),
        .rdata1 (rdata1)
    );

    // Valid bits: an unwritten channel reads as empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            rd_vld0_reg <= 1'b0;
            rd_vld1_reg <= 1'b0;
        end
        else
        begin
            rd_vld0_reg <= vld_lk0;
            rd_vld1_reg <= vld_lk1;
            if (ram_we)
            begin
                vld_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    // Capture the input beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg     <= channel;
            k_reg      <= k_in;
            above_reg  <= above_in;
            below_reg  <= below_in;
            e_draw_reg <= entry_draw;
            x_draw_reg <= exit_draw;
            hop_reg    <= hop_mask;
            up_reg     <= up_first_mask;
            a_site_reg <= attach_site;
            a_draw_reg <= attach_draw;
            d_site_reg <= detach_site;
            d_draw_reg <= detach_draw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oor_reg <= 1'b0;
        end
        else if (accept)
        begin
            oor_reg <= !in_ok;
        end
    end

    // Row above arrives the cycle before the row below and is held here
    always_ff @(posedge clk)
    begin
        if (st_reg == S_RD2)
        begin
            a_row_reg <= rdata1 & {CELLS{rd_vld1_reg}};
        end
    end

    // Entry and exit
    assign row0   = rdata0 & {CELLS{rd_vld0_reg}};
    assign b_row  = rdata1 & {CELLS{rd_vld1_reg}};
    assign e_fire = ({1'b0, e_draw_reg} <= entry_prob_reg);
    assign x_fire = ({1'b0, x_draw_reg} <= exit_prob_reg);
    assign ent    = e_fire && !row0[0];
    assign row1   = ent ? (row0 | ONE_BIT) : row0;
    assign ext    = x_fire && row1[CELLS-1];
    assign row2   = ext ? (row1 & ~LAST_BIT) : row1;

    // Cells that may hop or move: a fresh entry and the cell behind a fresh exit sit out
    assign span = (ext ? SPAN_EXIT : SPAN_FULL) & ~(ent ? ONE_BIT : '0);
    assign rsh  = row2 >> 1;

    // Lanes
    assign row_pad  = PAD_W'(row2);
    assign rsh_pad  = PAD_W'(rsh);
    assign span_pad = PAD_W'(span);
    assign hop_pad  = PAD_W'(hop_reg);
    assign up_pad   = PAD_W'(up_reg);
    assign a_pad    = PAD_W'(a_row_reg);
    assign b_pad    = PAD_W'(b_row);

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        mtel_pkg::lane_in_t  lin;
        mtel_pkg::lane_out_t lout;

        assign lin.row      = row_pad[l*LW +: LW];
        assign lin.rsh      = rsh_pad[l*LW +: LW];
        assign lin.span     = span_pad[l*LW +: LW];
        assign lin.hop      = hop_pad[l*LW +: LW];
        assign lin.up_first = up_pad[l*LW +: LW];
        assign lin.a_row    = a_pad[l*LW +: LW];
        assign lin.b_row    = b_pad[l*LW +: LW];
        assign lin.lat_en   = lat_en_reg;

        mtel_lane u_lane (
            .lin  (lin),
            .lout (lout)
        );

        assign hops_pad[l*LW +: LW]  = lout.hops;
        assign go_up_pad[l*LW +: LW] = lout.go_up;
        assign go_dn_pad[l*LW +: LW] = lout.go_dn;
        assign lane_hop_cnt[l]       = lout.hop_cnt;
        assign lane_lat_cnt[l]       = lout.lat_cnt;
    end

    assign hops  = hops_pad[CELLS-1:0];
    assign go_up = go_up_pad[CELLS-1:0];
    assign go_dn = go_dn_pad[CELLS-1:0];

    // Apply hops and lateral departures
    assign row3 = (row2 & ~hops) | (hops << 1);
    assign row4 = row3 & ~(go_up | go_dn);

    // Attach, then detach
    assign a_in  = (a_site_reg != '0) && (int'(a_site_reg) <= CELLS - 2);
    assign d_in  = (d_site_reg != '0) && (int'(d_site_reg) <= CELLS - 2);
    assign a_bit = ONE_BIT << a_site_reg;
    assign d_bit = ONE_BIT << d_site_reg;
    assign att   = (attach_prob_reg != '0) && a_in && ({1'b0, a_draw_reg} <= attach_prob_reg)
                   && ((row4 & a_bit) == '0);
    assign row5  = att ? (row4 | a_bit) : row4;
    assign det   = (detach_prob_reg != '0) && d_in && ({1'b0, d_draw_reg} <= detach_prob_reg)
                   && ((row5 & d_bit) != '0);
    assign row6  = det ? (row5 & ~d_bit) : row5;

    // Register the step results
    always_ff @(posedge clk)
    begin
        if (st_reg == S_CALC)
        begin
            res_row_reg      <= row6;
            b_row_reg        <= b_row;
            go_up_reg        <= go_up;
            go_dn_reg        <= go_dn;
            ent_reg          <= ent;
            ext_reg          <= ext;
            att_reg          <= att;
            det_reg          <= det;
            lane_hop_cnt_reg <= lane_hop_cnt;
            lane_lat_cnt_reg <= lane_lat_cnt;
        end
    end

    // Merge lane counts
    mtel_merge u_merge (
        .lane_hop_cnt  (lane_hop_cnt_reg),
        .lane_lat_cnt  (lane_lat_cnt_reg),
        .hop_count     (hop_sum),
        .lateral_count (lat_sum)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            updated_channel_reg <= ch_reg;
            row_bits_reg        <= oor_reg ? '0 : res_row_reg;
            entered_reg         <= !oor_reg && ent_reg;
            exited_reg          <= !oor_reg && ext_reg;
            hop_count_reg       <= oor_reg ? '0 : hop_sum;
            lateral_count_reg   <= oor_reg ? '0 : lat_sum;
            attached_reg        <= !oor_reg && att_reg;
            detached_reg        <= !oor_reg && det_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign updated_channel = updated_channel_reg;
    assign row_bits        = row_bits_reg;
    assign entered         = entered_reg;
    assign exited          = exited_reg;
    assign hop_count       = hop_count_reg;
    assign lateral_count   = lateral_count_reg;
    assign attached        = attached_reg;
    assign detached        = detached_reg;

    // Checks
    a_out_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(st_reg == S_DONE))
        else $error("result beat appeared outside the result load state");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (st_reg != S_IDLE))
        else $error("sequencer stayed idle after an accepted beat");

    a_ram_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((st_reg == S_CALC) || (st_reg == S_WRA) || (st_reg == S_WRB)))
        else $error("row RAM written outside the write-back states");

    a_oor_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && (st_reg == S_CALC)) |-> !oor_reg)
        else $error("row written back for an out-of-range channel");

endmodule

`default_nettype wire
